// ===== sv/gpio_controller_registers_assert.svh =====
// Assertion macros shared by the GPIO register block RTL.
`ifndef GPIO_CONTROLLER_REGISTERS_ASSERT_SVH
`define GPIO_CONTROLLER_REGISTERS_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define GCR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("gpio register block assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define GCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gpio register block assertion failed");

`else

`define GCR_ASSERT(label, clk, rst, prop)
`define GCR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/gpioc_pkg.sv =====
// Types and constants of the GPIO register block.
package gpioc_pkg;

   // Default pin count
   localparam int NUM_PINS_DEF = 54;

   // Function select layout
   localparam int FSEL_WORDS    = 6;
   localparam int FSEL_BITS     = 30;
   localparam int PINS_PER_WORD = 10;
   localparam int CODE_BITS     = 3;

   localparam logic [CODE_BITS-1:0] FSEL_OUTPUT = 3'd1;

   // Pull state codes
   localparam logic [1:0] PULL_DOWN = 2'd1;
   localparam logic [1:0] PULL_UP   = 2'd2;

   // Word indexes (byte offset bits 7:2)
   localparam logic [5:0] WORD_FSEL_LAST = 6'h05;
   localparam logic [5:0] WORD_SET0      = 6'h07;
   localparam logic [5:0] WORD_SET1      = 6'h08;
   localparam logic [5:0] WORD_CLR0      = 6'h0a;
   localparam logic [5:0] WORD_CLR1      = 6'h0b;
   localparam logic [5:0] WORD_LEV0      = 6'h0d;
   localparam logic [5:0] WORD_LEV1      = 6'h0e;
   localparam logic [5:0] WORD_PULL      = 6'h25;
   localparam logic [5:0] WORD_PCLK0     = 6'h26;
   localparam logic [5:0] WORD_PCLK1     = 6'h27;

   // One accepted bus beat as seen by the register bank
   typedef struct packed {
      logic        valid;
      logic        wr;
      logic [5:0]  word;
      logic [31:0] data;
   } access_type;

endpackage

// ===== sv/gpioc_bank.sv =====
// GPIO register bank: state, access decode and pin views.
module gpioc_bank
   import gpioc_pkg::*;
#(
   parameter int NUM_PINS = NUM_PINS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  access_type          acc,
   input  logic [NUM_PINS-1:0] pad_in,
   output logic [31:0]         rd_data,
   output logic [NUM_PINS-1:0] pin_out,
   output logic [NUM_PINS-1:0] drive_en,
   output logic [NUM_PINS-1:0] pull_up,
   output logic [NUM_PINS-1:0] pull_dn
);

   logic [FSEL_BITS-1:0] fsel_ff [FSEL_WORDS];
   logic [FSEL_BITS-1:0] fsel_in [FSEL_WORDS];
   logic [NUM_PINS-1:0]  latch_ff, latch_in;
   logic [1:0]           pull_ctl_ff, pull_ctl_in;
   logic [NUM_PINS-1:0]  pclk_ff, pclk_in;
   logic [1:0]           pull_st_ff [NUM_PINS];
   logic [1:0]           pull_st_in [NUM_PINS];

   logic [63:0]          half_vec;
   logic [63:0]          level_vec;
   logic [63:0]          pclk_vec;
   logic [63:0]          pclk_new;
   logic [NUM_PINS-1:0]  rise;

   // Decode drive enables and pull views per pin
   for (genvar i = 0; i < NUM_PINS; i++) begin : g_pin
      localparam int W = i / PINS_PER_WORD;
      localparam int B = (i % PINS_PER_WORD) * CODE_BITS;
      if (W < FSEL_WORDS) begin : g_fsel
         assign drive_en[i] = (fsel_ff[W][B +: CODE_BITS] == FSEL_OUTPUT);
      end else begin : g_nofsel
         assign drive_en[i] = 1'b0;
      end
      assign pull_up[i] = (pull_st_ff[i] == PULL_UP);
      assign pull_dn[i] = (pull_st_ff[i] == PULL_DOWN);
   end

   assign pin_out = latch_ff;

   // Compute next state and read word for the current beat
   always_comb begin
      fsel_in     = fsel_ff;
      latch_in    = latch_ff;
      pull_ctl_in = pull_ctl_ff;
      pclk_in     = pclk_ff;
      pull_st_in  = pull_st_ff;
      rd_data     = 32'h0;

      half_vec = '0;
      if (acc.word == WORD_SET1 || acc.word == WORD_CLR1) begin
         half_vec[63:32] = acc.data;
      end else begin
         half_vec[31:0] = acc.data;
      end

      level_vec = '0;
      level_vec[NUM_PINS-1:0] = (latch_ff & drive_en) | (pad_in & ~drive_en);

      pclk_vec = '0;
      pclk_vec[NUM_PINS-1:0] = pclk_ff;
      pclk_new = pclk_vec;
      if (acc.word == WORD_PCLK1) begin
         pclk_new[63:32] = acc.data;
      end else begin
         pclk_new[31:0] = acc.data;
      end
      rise = pclk_new[NUM_PINS-1:0] & ~pclk_ff;

      if (acc.word <= WORD_FSEL_LAST) begin
         if (acc.wr) begin
            fsel_in[acc.word[2:0]] = acc.data[FSEL_BITS-1:0];
         end else begin
            rd_data = {{(32-FSEL_BITS){1'b0}}, fsel_ff[acc.word[2:0]]};
         end
      end else begin
         case (acc.word)
            WORD_SET0, WORD_SET1: begin
               if (acc.wr) latch_in = latch_ff | half_vec[NUM_PINS-1:0];
            end
            WORD_CLR0, WORD_CLR1: begin
               if (acc.wr) latch_in = latch_ff & ~half_vec[NUM_PINS-1:0];
            end
            WORD_LEV0: begin
               if (!acc.wr) rd_data = level_vec[31:0];
            end
            WORD_LEV1: begin
               if (!acc.wr) rd_data = level_vec[63:32];
            end
            WORD_PULL: begin
               if (acc.wr) begin
                  pull_ctl_in = acc.data[1:0];
               end else begin
                  rd_data = {30'h0, pull_ctl_ff};
               end
            end
            WORD_PCLK0, WORD_PCLK1: begin
               if (acc.wr) begin
                  pclk_in = pclk_new[NUM_PINS-1:0];
                  for (int i = 0; i < NUM_PINS; i++) begin
                     if (rise[i]) pull_st_in[i] = pull_ctl_ff;
                  end
               end else if (acc.word == WORD_PCLK1) begin
                  rd_data = pclk_vec[63:32];
               end else begin
                  rd_data = pclk_vec[31:0];
               end
            end
            default: begin
               rd_data = 32'h0;
            end
         endcase
      end
   end

   // Advance state on every accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < FSEL_WORDS; w++) fsel_ff[w] <= '0;
         latch_ff    <= '0;
         pull_ctl_ff <= '0;
         pclk_ff     <= '0;
         for (int i = 0; i < NUM_PINS; i++) pull_st_ff[i] <= '0;
      end else if (acc.valid) begin
         fsel_ff     <= fsel_in;
         latch_ff    <= latch_in;
         pull_ctl_ff <= pull_ctl_in;
         pclk_ff     <= pclk_in;
         pull_st_ff  <= pull_st_in;
      end
   end

endmodule

// ===== sv/gpio_controller_registers.sv =====
// GPIO controller register block top level.
//
// Usage: each req_ beat is one register access (req_mode 0 read, 1 write)
// at byte offset req_address with req_write_data and the sampled pad
// levels req_pad_in. Every accepted beat yields exactly one rsp_ beat:
// rsp_read_data holds the word read (zero on writes, unmapped offsets and
// set/clear words), and the pin views show the state after the access.
// Response: registered, and valid in the cycle after the request beat.
// Throughput: one access per cycle; state update and read decode are a
// single pass of logic between the request handshake and the response
// register, so a new beat is taken in the same cycle the old response
// leaves. While rsp_ready is low with a response pending, req_ready drops
// and the register state and response hold.
// Reset: all function selects input, output latch, pull control, pull
// clocks and pull states zero; no response pending.
`include "gpio_controller_registers_assert.svh"

module gpio_controller_registers
   import gpioc_pkg::*;
#(
   parameter int NUM_PINS = NUM_PINS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_mode,
   input  logic [7:0]          req_address,
   input  logic [31:0]         req_write_data,
   input  logic [NUM_PINS-1:0] req_pad_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [31:0]         rsp_read_data,
   output logic [NUM_PINS-1:0] rsp_pin_out,
   output logic [NUM_PINS-1:0] rsp_pin_drive_enable,
   output logic [NUM_PINS-1:0] rsp_pull_up_on,
   output logic [NUM_PINS-1:0] rsp_pull_down_on
);

   access_type  acc;
   logic        accept;
   logic [31:0] rd_data;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] read_data_ff;

   // Take a beat whenever the response slot is free or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign acc.valid = accept;
   assign acc.wr    = req_mode;
   assign acc.word  = req_address[7:2];
   assign acc.data  = req_write_data;

   gpioc_bank #(
      .NUM_PINS (NUM_PINS)
   ) u_bank (
      .clock    (clock),
      .reset    (reset),
      .acc      (acc),
      .pad_in   (req_pad_in),
      .rd_data  (rd_data),
      .pin_out  (rsp_pin_out),
      .drive_en (rsp_pin_drive_enable),
      .pull_up  (rsp_pull_up_on),
      .pull_dn  (rsp_pull_down_on)
   );

   // Hold the response until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture read word; writes return zero
   always_ff @(posedge clock) begin
      if (accept) begin
         read_data_ff <= req_mode ? 32'h0 : rd_data;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = read_data_ff;

   `GCR_ASSERT(a_stall_blocks_req, clock, reset, !(rsp_valid_ff && !rsp_ready) || !req_ready)
   `GCR_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, accept, rsp_valid_ff)
   `GCR_ASSERT_NEXT(a_write_reads_zero, clock, reset, accept && req_mode, read_data_ff == 32'h0)
   `GCR_ASSERT_NEXT(a_latch_only_on_beat, clock, reset, !accept, $stable(rsp_pin_out))

endmodule
